FILE: hdl/twd_pkg.sv
// Shared types, codes and reset constants for the task watchdog supervisor.
`default_nettype none
package twd_pkg;

  localparam int MAX_TASKS  = 5;
  localparam int TASKS_DEF  = 5;
  localparam int TIME_W     = 32;
  localparam int DL_W       = 16;
  localparam int CMD_W      = 3;
  localparam int ID_W       = 3;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_KICK    = 3'd1,
    CMD_FAULT   = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_SERVICE = 3'd4,
    CMD_RESTART = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    BLAME_NONE   = 2'd0,
    BLAME_FAULTS = 2'd1,
    BLAME_TASK   = 2'd2
  } blame_t;

  localparam logic [REG_IDX_W-1:0] REG_GRACE = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT = 3'd6;

  localparam logic [DL_W-1:0]   DEADLINE_RESET [MAX_TASKS] = '{
    16'd500, 16'd500, 16'd1000, 16'd2000, 16'd2000
  };
  localparam logic [DL_W-1:0]   GRACE_RESET = 16'd15000;
  localparam logic [TIME_W-1:0] LIMIT_RESET = 32'd10;
  localparam logic [TIME_W-1:0] FAULT_MAX   = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_GRACE,
    ST_FAULT,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    OP_GRACE,
    OP_FAULT,
    OP_TASK
  } op_sel_t;

  // result of the shared subtract-compare unit: (a - b) against lim
  typedef struct packed {
    logic lt;
    logic gt;
  } cmp_t;

endpackage
`default_nettype wire

FILE: hdl/twd_subcmp.sv
// Shared unit: modulo-2^32 difference of two timestamps compared with a limit.
`default_nettype none
module twd_subcmp
  import twd_pkg::*;
(
  input  wire logic [TIME_W-1:0] a,
  input  wire logic [TIME_W-1:0] b,
  input  wire logic [TIME_W-1:0] lim,
  output cmp_t                   result
);

  logic [TIME_W-1:0] diff;

  assign diff      = a - b;
  assign result.lt = (diff < lim);
  assign result.gt = (diff > lim);

endmodule
`default_nettype wire

FILE: hdl/task_aggregated_watchdog.sv
// Top level: sequencer, state registers and channels of the task watchdog supervisor.
//
// channel | signals                                         | direction
// in      | in_valid, in_stall, command, task_id            | request in
// out     | out_valid, out_stall, feed_pulse, blame_kind,   | result out
//         | blame_task, fault_count                         |
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data       | register write in
//
// Requests are accepted only in IDLE, so a new one waits until the last result
// is loaded. Non-service requests go EXEC then OUT; service goes EXEC, GRACE
// (ends in grace), FAULT (ends at the fault limit), then SCAN, one task per cycle
// through the shared subtract-compare unit until a task is blamed or all tasks
// are healthy. A result held by out_stall delays the next accept. Synchronous
// reset restores the register defaults, clears the supervisor state and out_valid.
`default_nettype none
module task_aggregated_watchdog
  import twd_pkg::*;
#(
  parameter int TASKS = TASKS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [CMD_W-1:0]     command,
  input  wire logic [ID_W-1:0]      task_id,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      feed_pulse,
  output logic [1:0]                blame_kind,
  output logic [ID_W-1:0]           blame_task,
  output logic [TIME_W-1:0]         fault_count,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_W-1:0]    cfg_data
);

  localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam logic [ID_W-1:0]  TASK_LIM = ID_W'(TASKS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASKS - 1);

  state_t state, state_next;

  logic [DL_W-1:0]   deadline [TASKS];
  logic [DL_W-1:0]   grace_ms;
  logic [TIME_W-1:0] fault_limit;

  logic [TIME_W-1:0] time_now;
  logic [TIME_W-1:0] boot_time;
  logic [TIME_W-1:0] last_kick [TASKS];
  logic [TASKS-1:0]  task_started;
  logic [TIME_W-1:0] fault_counter;
  blame_t            blame_kind_reg;
  logic [ID_W-1:0]   blame_task_reg;
  logic              feed_reg;

  cmd_t              cmd;
  logic [ID_W-1:0]   id;
  logic [IDX_W-1:0]  scan_idx;

  op_sel_t           op_sel;
  logic [TIME_W-1:0] op_a, op_b, op_lim;
  cmp_t              cmp;
  logic              out_free;
  logic              out_load;
  logic              task_bad;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign task_bad  = !task_started[scan_idx] || cmp.gt;

  // operand select for the shared unit
  always_comb begin
    unique case (op_sel)
      OP_GRACE: begin
        op_a   = time_now;
        op_b   = boot_time;
        op_lim = {{(TIME_W-DL_W){1'b0}}, grace_ms};
      end
      OP_FAULT: begin
        op_a   = fault_counter;
        op_b   = '0;
        op_lim = fault_limit;
      end
      default: begin
        op_a   = time_now;
        op_b   = last_kick[scan_idx];
        op_lim = {{(TIME_W-DL_W){1'b0}}, deadline[scan_idx]};
      end
    endcase
  end

  twd_subcmp u_subcmp (
    .a      (op_a),
    .b      (op_b),
    .lim    (op_lim),
    .result (cmp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_EXEC;
      ST_EXEC:  state_next = (cmd == CMD_SERVICE) ? ST_GRACE : ST_OUT;
      ST_GRACE: state_next = cmp.lt ? ST_OUT : ST_FAULT;
      ST_FAULT: state_next = cmp.lt ? ST_SCAN : ST_OUT;
      ST_SCAN:  if (task_bad || scan_idx == LAST_IDX) state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    unique case (state)
      ST_GRACE: op_sel = OP_GRACE;
      ST_FAULT: op_sel = OP_FAULT;
      default:  op_sel = OP_TASK;
    endcase
    out_load = (state == ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture and scan index
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cmd <= cmd_t'(command);
      id  <= task_id;
    end
    if (state == ST_FAULT) begin
      scan_idx <= '0;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASKS; i++) begin
        deadline[i] <= DEADLINE_RESET[i];
      end
      grace_ms    <= GRACE_RESET;
      fault_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index < TASK_LIM) begin
        deadline[cfg_index[IDX_W-1:0]] <= cfg_data[DL_W-1:0];
      end else if (cfg_index == REG_GRACE) begin
        grace_ms <= cfg_data[DL_W-1:0];
      end else if (cfg_index == REG_LIMIT) begin
        fault_limit <= cfg_data;
      end
    end
  end

  // supervisor state
  always_ff @(posedge clk) begin
    if (rst) begin
      time_now       <= '0;
      boot_time      <= '0;
      for (int i = 0; i < TASKS; i++) begin
        last_kick[i] <= '0;
      end
      task_started   <= '0;
      fault_counter  <= '0;
      blame_kind_reg <= BLAME_NONE;
      blame_task_reg <= '0;
      feed_reg       <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) feed_reg <= 1'b0;
        end
        ST_EXEC: begin
          unique case (cmd)
            CMD_TICK: time_now <= time_now + 1'b1;
            CMD_KICK: begin
              if (id < TASK_LIM) begin
                last_kick[id[IDX_W-1:0]]    <= time_now;
                task_started[id[IDX_W-1:0]] <= 1'b1;
              end
            end
            CMD_FAULT: begin
              if (fault_counter != FAULT_MAX) fault_counter <= fault_counter + 1'b1;
            end
            CMD_CLEAR: fault_counter <= '0;
            CMD_RESTART: begin
              boot_time <= time_now;
              for (int i = 0; i < TASKS; i++) begin
                last_kick[i] <= time_now;
              end
              task_started   <= '0;
              fault_counter  <= '0;
              blame_kind_reg <= BLAME_NONE;
              blame_task_reg <= '0;
            end
            default: ;
          endcase
        end
        ST_GRACE: begin
          if (cmp.lt) begin
            blame_kind_reg <= BLAME_NONE;
            blame_task_reg <= '0;
            feed_reg       <= 1'b1;
          end
        end
        ST_FAULT: begin
          // fault_counter - 0 not below limit: limit reached
          if (!cmp.lt) begin
            blame_kind_reg <= BLAME_FAULTS;
            blame_task_reg <= '0;
          end
        end
        ST_SCAN: begin
          if (task_bad) begin
            blame_kind_reg <= BLAME_TASK;
            blame_task_reg <= ID_W'(scan_idx);
          end else if (scan_idx == LAST_IDX) begin
            blame_kind_reg <= BLAME_NONE;
            blame_task_reg <= '0;
            feed_reg       <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      feed_pulse  <= feed_reg;
      blame_kind  <= blame_kind_reg;
      blame_task  <= blame_task_reg;
      fault_count <= fault_counter;
    end
  end

endmodule
`default_nettype wire
